// ===== rtl/core/keh_pkg.sv =====
package keh_pkg;

  localparam int unsigned KEY_SLOTS = 70;
  localparam int unsigned IDX_W     = 7;

  localparam logic [7:0]       NO_EVENT     = 8'hFF;
  localparam logic [IDX_W-1:0] KEY_SLOTS_IX = IDX_W'(KEY_SLOTS);
  localparam logic [IDX_W-1:0] COLS_PER_ROW = 7'd14;
  localparam logic [IDX_W-1:0] SYM_KEY      = 7'd42;
  localparam logic [IDX_W-1:0] SHIFT_KEY    = 7'd43;
  localparam logic [IDX_W-1:0] CTRL_KEY     = 7'd56;
  localparam logic [IDX_W-1:0] ALT_KEY      = 7'd57;

  localparam logic [2:0] MOD_CTRL  = 3'b001;
  localparam logic [2:0] MOD_SHIFT = 3'b010;
  localparam logic [2:0] MOD_ALT   = 3'b100;

  localparam logic MODE_EVENT = 1'b0;
  localparam logic MODE_FAULT = 1'b1;

  localparam logic ACT_REPORT  = 1'b0;
  localparam logic ACT_RELEASE = 1'b1;

  typedef struct packed {
    logic       mode;
    logic [7:0] event_byte;
  } evt_t;

  typedef struct packed {
    logic       action;
    logic [2:0] modifiers;
    logic [7:0] usage_id;
  } rpt_t;

  // entry: bit 8 = force shift, bits 7:0 = usage
  typedef logic [8:0] key_entry_t;

  localparam key_entry_t BASE_TAB [KEY_SLOTS] = '{
    9'h029, 9'h01E, 9'h01F, 9'h020, 9'h021, 9'h022, 9'h023,
    9'h024, 9'h025, 9'h026, 9'h027, 9'h02D, 9'h12E, 9'h04C,
    9'h035, 9'h11E, 9'h11F, 9'h120, 9'h121, 9'h122, 9'h123,
    9'h124, 9'h125, 9'h126, 9'h127, 9'h02F, 9'h030, 9'h031,
    9'h02B, 9'h014, 9'h01A, 9'h008, 9'h015, 9'h017, 9'h01C,
    9'h018, 9'h00C, 9'h012, 9'h013, 9'h033, 9'h034, 9'h02A,
    9'h000, 9'h000, 9'h004, 9'h016, 9'h007, 9'h009, 9'h00A,
    9'h00B, 9'h00D, 9'h00E, 9'h00F, 9'h052, 9'h12D, 9'h028,
    9'h000, 9'h000, 9'h01D, 9'h01B, 9'h006, 9'h019, 9'h005,
    9'h011, 9'h010, 9'h037, 9'h050, 9'h051, 9'h04F, 9'h02C
  };

  localparam key_entry_t SYM_TAB [KEY_SLOTS] = '{
    9'h029, 9'h01E, 9'h01F, 9'h020, 9'h021, 9'h022, 9'h023,
    9'h024, 9'h025, 9'h026, 9'h027, 9'h02D, 9'h12E, 9'h04C,
    9'h135, 9'h138, 9'h11F, 9'h120, 9'h121, 9'h122, 9'h123,
    9'h124, 9'h038, 9'h136, 9'h137, 9'h12F, 9'h130, 9'h131,
    9'h02B, 9'h014, 9'h01A, 9'h008, 9'h015, 9'h017, 9'h01C,
    9'h018, 9'h00C, 9'h012, 9'h013, 9'h133, 9'h134, 9'h02A,
    9'h000, 9'h000, 9'h004, 9'h016, 9'h007, 9'h009, 9'h00A,
    9'h00B, 9'h00D, 9'h00E, 9'h00F, 9'h052, 9'h02E, 9'h028,
    9'h000, 9'h000, 9'h01D, 9'h01B, 9'h006, 9'h019, 9'h005,
    9'h011, 9'h010, 9'h036, 9'h050, 9'h051, 9'h04F, 9'h02C
  };

endpackage

// ===== rtl/core/keh_decode.sv =====
module keh_decode
  import keh_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic fire,
  input  evt_t item,
  output logic has_rpt,
  output rpt_t rpt
);

  logic sym_latch, shift_latch, ctrl_latch, alt_latch;
  logic sym_latch_next, shift_latch_next, ctrl_latch_next, alt_latch_next;

  logic             pressed;
  logic [2:0]       row;
  logic [3:0]       col;
  logic [IDX_W-1:0] idx;
  logic [IDX_W-1:0] tidx;
  logic             in_range;
  logic             is_mod_key;
  key_entry_t       entry;
  logic [2:0]       mods;

  assign pressed    = item.event_byte[7];
  assign row        = item.event_byte[6:4];
  assign col        = item.event_byte[3:0];
  assign idx        = IDX_W'({4'b0, row} * COLS_PER_ROW) + {3'b0, col};
  assign in_range   = idx < KEY_SLOTS_IX;
  assign tidx       = in_range ? idx : '0;
  assign is_mod_key = (idx == SYM_KEY) || (idx == SHIFT_KEY) ||
                      (idx == CTRL_KEY) || (idx == ALT_KEY);
  assign entry      = sym_latch ? SYM_TAB[tidx] : BASE_TAB[tidx];

  always_comb begin
    sym_latch_next   = sym_latch;
    shift_latch_next = shift_latch;
    ctrl_latch_next  = ctrl_latch;
    alt_latch_next   = alt_latch;
    has_rpt          = 1'b0;
    rpt              = '0;
    mods             = '0;
    if (item.mode == MODE_FAULT) begin
      sym_latch_next   = 1'b0;
      shift_latch_next = 1'b0;
      ctrl_latch_next  = 1'b0;
      alt_latch_next   = 1'b0;
      has_rpt          = 1'b1;
      rpt.action       = ACT_RELEASE;
    end else if (item.event_byte != NO_EVENT && in_range) begin
      if (!pressed) begin
        if (!is_mod_key) begin
          has_rpt    = 1'b1;
          rpt.action = ACT_RELEASE;
        end
      end else begin
        case (idx)
          SYM_KEY:   sym_latch_next   = !sym_latch;
          SHIFT_KEY: shift_latch_next = !shift_latch;
          CTRL_KEY:  ctrl_latch_next  = !ctrl_latch;
          ALT_KEY:   alt_latch_next   = !alt_latch;
          default: begin
            sym_latch_next = 1'b0;
            if (entry[7:0] != 8'h00) begin
              if (entry[8] || shift_latch) mods = mods | MOD_SHIFT;
              if (ctrl_latch) mods = mods | MOD_CTRL;
              if (alt_latch) mods = mods | MOD_ALT;
              shift_latch_next = 1'b0;
              ctrl_latch_next  = 1'b0;
              alt_latch_next   = 1'b0;
              has_rpt          = 1'b1;
              rpt.action       = ACT_REPORT;
              rpt.modifiers    = mods;
              rpt.usage_id     = entry[7:0];
            end
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sym_latch   <= 1'b0;
      shift_latch <= 1'b0;
      ctrl_latch  <= 1'b0;
      alt_latch   <= 1'b0;
    end else if (fire) begin
      sym_latch   <= sym_latch_next;
      shift_latch <= shift_latch_next;
      ctrl_latch  <= ctrl_latch_next;
      alt_latch   <= alt_latch_next;
    end
  end

endmodule

// ===== rtl/core/keh_out_reg.sv =====
module keh_out_reg
  import keh_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic load_valid,
  input  rpt_t load_data,
  output logic can_load,
  output logic rpt_valid,
  input  logic rpt_ready,
  output rpt_t rpt
);

  assign can_load = !rpt_valid || rpt_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      rpt_valid <= 1'b0;
    end else if (can_load) begin
      rpt_valid <= load_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (can_load && load_valid) begin
      rpt <= load_data;
    end
  end

endmodule

// ===== rtl/core/key_event_to_hid_report.sv =====
// Key event to HID keyboard report converter with one-shot modifiers.
// Request channel evt: mode (0 key event, 1 bus fault) and event_byte
// (bit 7 pressed, bits 6-4 row, bits 3-0 column). Response channel rpt:
// action (0 key report, 1 release all), modifiers and usage_id.
// Both channels use valid/ready; a request moves when valid and ready are
// both high at a rising edge.
// A request is registered on acceptance, decoded against the sym, shift,
// ctrl and alt latches in the next cycle and its response, if any, lands in
// the output register when that register is free or being drained.
// Throughput is one request per cycle unless the output stalls; requests
// that give no response (no-event byte, out-of-range key, modifier presses
// and releases, zero usage) still pass the decode stage and update the
// latches in order. When the receiver stalls, the output register holds its
// response and the input register fills; evt_ready drops only when both are
// occupied. Synchronous reset clears both stages and all four latches.
module key_event_to_hid_report
  import keh_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic evt_valid,
  output logic evt_ready,
  input  evt_t evt,
  output logic rpt_valid,
  input  logic rpt_ready,
  output rpt_t rpt
);

  logic s1_valid;
  evt_t s1;
  logic s1_adv;
  logic can_load;
  logic has_rpt;
  rpt_t dec_rpt;

  assign s1_adv    = s1_valid && can_load;
  assign evt_ready = !s1_valid || can_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (evt_ready) begin
      s1_valid <= evt_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (evt_ready && evt_valid) begin
      s1 <= evt;
    end
  end

  keh_decode u_decode (
    .clk     (clk),
    .rst     (rst),
    .fire    (s1_adv),
    .item    (s1),
    .has_rpt (has_rpt),
    .rpt     (dec_rpt)
  );

  keh_out_reg u_out_reg (
    .clk        (clk),
    .rst        (rst),
    .load_valid (s1_adv && has_rpt),
    .load_data  (dec_rpt),
    .can_load   (can_load),
    .rpt_valid  (rpt_valid),
    .rpt_ready  (rpt_ready),
    .rpt        (rpt)
  );

`ifndef NO_ASSERTIONS
  a_fault_releases: assert property (@(posedge clk) disable iff (rst)
    s1_adv && s1.mode == MODE_FAULT |=> rpt_valid && rpt.action == ACT_RELEASE)
    else $error("bus fault did not produce a release-all response");

  a_no_stall_when_out_free: assert property (@(posedge clk) disable iff (rst)
    !rpt_valid |-> evt_ready)
    else $error("input stalled while output register is free");

  a_report_nonzero: assert property (@(posedge clk) disable iff (rst)
    rpt_valid && rpt.action == ACT_REPORT |-> rpt.usage_id != 8'h00)
    else $error("key report with zero usage");

  a_release_clean: assert property (@(posedge clk) disable iff (rst)
    rpt_valid && rpt.action == ACT_RELEASE |-> rpt.usage_id == 8'h00 &&
      rpt.modifiers == 3'b000)
    else $error("release-all carries usage or modifiers");
`endif

endmodule

// ===== tb/sv/tb_top.sv =====
module tb_top
  import keh_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_ITEMS = 1520;
  localparam int CYCLE_LIMIT  = 100000;
  localparam int IDLE_PCT     = 35;

  localparam logic [7:0] BASE_USAGE [70] = '{
    8'h29, 8'h1E, 8'h1F, 8'h20, 8'h21, 8'h22, 8'h23, 8'h24, 8'h25, 8'h26, 8'h27, 8'h2D, 8'h2E, 8'h4C,
    8'h35, 8'h1E, 8'h1F, 8'h20, 8'h21, 8'h22, 8'h23, 8'h24, 8'h25, 8'h26, 8'h27, 8'h2F, 8'h30, 8'h31,
    8'h2B, 8'h14, 8'h1A, 8'h08, 8'h15, 8'h17, 8'h1C, 8'h18, 8'h0C, 8'h12, 8'h13, 8'h33, 8'h34, 8'h2A,
    8'h00, 8'h00, 8'h04, 8'h16, 8'h07, 8'h09, 8'h0A, 8'h0B, 8'h0D, 8'h0E, 8'h0F, 8'h52, 8'h2D, 8'h28,
    8'h00, 8'h00, 8'h1D, 8'h1B, 8'h06, 8'h19, 8'h05, 8'h11, 8'h10, 8'h37, 8'h50, 8'h51, 8'h4F, 8'h2C
  };
  localparam bit BASE_SHIFTED [70] = '{
    0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1, 0,
    0, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 0, 0, 0,
    0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0,
    0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1, 0,
    0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0
  };
  localparam logic [7:0] SYM_USAGE [70] = '{
    8'h29, 8'h1E, 8'h1F, 8'h20, 8'h21, 8'h22, 8'h23, 8'h24, 8'h25, 8'h26, 8'h27, 8'h2D, 8'h2E, 8'h4C,
    8'h35, 8'h38, 8'h1F, 8'h20, 8'h21, 8'h22, 8'h23, 8'h24, 8'h38, 8'h36, 8'h37, 8'h2F, 8'h30, 8'h31,
    8'h2B, 8'h14, 8'h1A, 8'h08, 8'h15, 8'h17, 8'h1C, 8'h18, 8'h0C, 8'h12, 8'h13, 8'h33, 8'h34, 8'h2A,
    8'h00, 8'h00, 8'h04, 8'h16, 8'h07, 8'h09, 8'h0A, 8'h0B, 8'h0D, 8'h0E, 8'h0F, 8'h52, 8'h2E, 8'h28,
    8'h00, 8'h00, 8'h1D, 8'h1B, 8'h06, 8'h19, 8'h05, 8'h11, 8'h10, 8'h36, 8'h50, 8'h51, 8'h4F, 8'h2C
  };
  localparam bit SYM_SHIFTED [70] = '{
    0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1, 0,
    1, 1, 1, 1, 1, 1, 1, 1, 0, 1, 1, 1, 1, 1,
    0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1, 1, 0,
    0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0,
    0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0
  };

  typedef struct {
    evt_t e;
    bit   drain;
  } key_req_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic evt_valid = 1'b0;
  logic evt_ready;
  evt_t evt = '0;
  logic rpt_valid;
  logic rpt_ready = 1'b0;
  rpt_t rpt;

  key_req_t key_requests [$];
  rpt_t     expected_reports [$];

  bit sym_armed, shift_armed, ctrl_armed, alt_armed;
  int errors = 0;
  int cycle_count = 0;
  int quiet_cycles = 0;

  key_event_to_hid_report u_top (
    .clk       (clk),
    .rst       (rst),
    .evt_valid (evt_valid),
    .evt_ready (evt_ready),
    .evt       (evt),
    .rpt_valid (rpt_valid),
    .rpt_ready (rpt_ready),
    .rpt       (rpt)
  );

  always #2 clk = ~clk;

  function automatic bit is_modifier_key(int idx);
    return idx == int'(SYM_KEY) || idx == int'(SHIFT_KEY) ||
           idx == int'(CTRL_KEY) || idx == int'(ALT_KEY);
  endfunction

  function automatic logic [7:0] key_byte(bit pressed, int idx);
    return {pressed, 3'(idx / int'(COLS_PER_ROW)), 4'(idx % int'(COLS_PER_ROW))};
  endfunction

  // Updates the sticky latches; returns 1 when the request yields a report.
  function automatic bit hid_report_for(input evt_t e, output rpt_t r);
    int         idx;
    logic [7:0] code;
    bit         shifted;
    r = '0;
    if (e.mode == MODE_FAULT) begin
      sym_armed = 0;
      shift_armed = 0;
      ctrl_armed = 0;
      alt_armed = 0;
      r.action = ACT_RELEASE;
      return 1;
    end
    if (e.event_byte == NO_EVENT) return 0;
    idx = int'(e.event_byte[6:4]) * int'(COLS_PER_ROW) + int'(e.event_byte[3:0]);
    if (idx >= int'(KEY_SLOTS)) return 0;
    if (!e.event_byte[7]) begin
      if (is_modifier_key(idx)) return 0;
      r.action = ACT_RELEASE;
      return 1;
    end
    if (idx == int'(SYM_KEY)) begin
      sym_armed = !sym_armed;
      return 0;
    end
    if (idx == int'(SHIFT_KEY)) begin
      shift_armed = !shift_armed;
      return 0;
    end
    if (idx == int'(CTRL_KEY)) begin
      ctrl_armed = !ctrl_armed;
      return 0;
    end
    if (idx == int'(ALT_KEY)) begin
      alt_armed = !alt_armed;
      return 0;
    end
    if (sym_armed) begin
      code = SYM_USAGE[idx];
      shifted = SYM_SHIFTED[idx];
      sym_armed = 0;
    end else begin
      code = BASE_USAGE[idx];
      shifted = BASE_SHIFTED[idx];
    end
    if (code == 8'h00) return 0;
    r.action = ACT_REPORT;
    r.usage_id = code;
    if (shifted || shift_armed) begin
      r.modifiers |= MOD_SHIFT;
      shift_armed = 0;
    end
    if (ctrl_armed) begin
      r.modifiers |= MOD_CTRL;
      ctrl_armed = 0;
    end
    if (alt_armed) begin
      r.modifiers |= MOD_ALT;
      alt_armed = 0;
    end
    return 1;
  endfunction

  function automatic void add_req(logic mode, logic [7:0] b, bit drain = 0);
    key_req_t q;
    q.e.mode = mode;
    q.e.event_byte = b;
    q.drain = drain;
    key_requests.push_back(q);
  endfunction

  function automatic bit calm();
    return cycle_count >= 1200 && cycle_count < 1800;
  endfunction

  // request driver
  always @(posedge clk) begin
    rpt_t r;
    bit   accepted;
    bit   go;
    accepted = 0;
    if (rst) begin
      evt_valid <= 1'b0;
      quiet_cycles <= 0;
    end else begin
      if (evt_valid && evt_ready) begin
        accepted = 1;
        if (hid_report_for(evt, r)) expected_reports.push_back(r);
      end
      quiet_cycles <= (accepted || expected_reports.size() != 0) ? 0 : quiet_cycles + 1;
      if (!evt_valid || evt_ready) begin
        go = key_requests.size() != 0 && (calm() || $urandom_range(99) >= IDLE_PCT);
        if (go && key_requests[0].drain)
          go = !accepted && !evt_valid && expected_reports.size() == 0 && quiet_cycles >= 4;
        if (go) begin
          evt <= key_requests[0].e;
          evt_valid <= 1'b1;
          void'(key_requests.pop_front());
        end else begin
          evt_valid <= 1'b0;
        end
      end
    end
  end

  // report monitor and receiver stalls
  always @(posedge clk) begin
    rpt_t x;
    if (rst) begin
      rpt_ready <= 1'b0;
    end else begin
      if (rpt_valid && rpt_ready) begin
        if (expected_reports.size() == 0) begin
          $error("unexpected report: action %0d modifiers %0d usage_id %02h",
                 rpt.action, rpt.modifiers, rpt.usage_id);
          errors++;
        end else begin
          x = expected_reports.pop_front();
          if (rpt.action !== x.action) begin
            $error("action: expected %0d, got %0d", x.action, rpt.action);
            errors++;
          end
          if (rpt.modifiers !== x.modifiers) begin
            $error("modifiers: expected %0d, got %0d", x.modifiers, rpt.modifiers);
            errors++;
          end
          if (rpt.usage_id !== x.usage_id) begin
            $error("usage_id: expected %02h, got %02h", x.usage_id, rpt.usage_id);
            errors++;
          end
        end
      end
      rpt_ready <= calm() || $urandom_range(99) >= IDLE_PCT;
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_top: errors");
      $finish;
    end
  end

  initial begin
    int r;
    int idx;
    // directed
    add_req(MODE_FAULT, 8'h00);
    add_req(MODE_EVENT, NO_EVENT);
    add_req(MODE_EVENT, 8'hD0);
    add_req(MODE_EVENT, key_byte(1, 70));
    add_req(MODE_EVENT, 8'h4F);
    add_req(MODE_EVENT, key_byte(1, 0));
    add_req(MODE_EVENT, key_byte(1, 12));
    add_req(MODE_EVENT, key_byte(0, 0));
    add_req(MODE_EVENT, key_byte(0, int'(SYM_KEY)));
    add_req(MODE_EVENT, key_byte(1, int'(SHIFT_KEY)));
    add_req(MODE_EVENT, key_byte(1, 44));
    add_req(MODE_EVENT, key_byte(1, int'(CTRL_KEY)));
    add_req(MODE_EVENT, key_byte(1, int'(ALT_KEY)));
    add_req(MODE_EVENT, key_byte(1, 69));
    add_req(MODE_EVENT, key_byte(1, int'(SYM_KEY)));
    add_req(MODE_EVENT, key_byte(1, 15));
    add_req(MODE_EVENT, key_byte(1, int'(SYM_KEY)));
    add_req(MODE_EVENT, key_byte(1, int'(SYM_KEY)));
    add_req(MODE_EVENT, key_byte(1, 15));
    add_req(MODE_EVENT, key_byte(1, int'(SHIFT_KEY)));
    add_req(MODE_EVENT, key_byte(1, int'(CTRL_KEY)));
    add_req(MODE_FAULT, 8'h5A);
    add_req(MODE_EVENT, key_byte(1, 0));
    add_req(MODE_FAULT, NO_EVENT);
    add_req(MODE_EVENT, 8'h7F, 1);

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      r = $urandom_range(99);
      if (r < 7) begin
        add_req(MODE_FAULT, 8'($urandom), i == 800);
      end else if (r < 15) begin
        add_req(MODE_EVENT, 8'($urandom), i == 800);
      end else if (r < 35) begin
        case ($urandom_range(3))
          0: idx = int'(SYM_KEY);
          1: idx = int'(SHIFT_KEY);
          2: idx = int'(CTRL_KEY);
          default: idx = int'(ALT_KEY);
        endcase
        add_req(MODE_EVENT, key_byte($urandom_range(9) != 0, idx), i == 800);
      end else begin
        do idx = $urandom_range(int'(KEY_SLOTS) - 1); while (is_modifier_key(idx));
        add_req(MODE_EVENT, key_byte(r >= 52, idx), i == 800);
      end
    end

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    while (key_requests.size() != 0 || evt_valid) @(posedge clk);
    while (expected_reports.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule
